FILE: hw/rtl/lc3_pkg.sv
// Shared types and constants for the LC-3 instruction executor.
package lc3_pkg;

	// Command codes
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_EXEC    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_HALT    = 3'd1;
	localparam logic [2:0] ST_ILLEGAL = 3'd2;
	localparam logic [2:0] ST_REFUSED = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	// Opcodes
	localparam logic [3:0] OP_BR   = 4'h0;
	localparam logic [3:0] OP_ADD  = 4'h1;
	localparam logic [3:0] OP_LD   = 4'h2;
	localparam logic [3:0] OP_ST   = 4'h3;
	localparam logic [3:0] OP_JSR  = 4'h4;
	localparam logic [3:0] OP_AND  = 4'h5;
	localparam logic [3:0] OP_LDR  = 4'h6;
	localparam logic [3:0] OP_STR  = 4'h7;
	localparam logic [3:0] OP_NOT  = 4'h9;
	localparam logic [3:0] OP_LDI  = 4'hA;
	localparam logic [3:0] OP_STI  = 4'hB;
	localparam logic [3:0] OP_JMP  = 4'hC;
	localparam logic [3:0] OP_LEA  = 4'hE;
	localparam logic [3:0] OP_TRAP = 4'hF;

	// Trap vectors
	localparam logic [7:0] TV_GETC = 8'h20;
	localparam logic [7:0] TV_OUT  = 8'h21;
	localparam logic [7:0] TV_IN   = 8'h23;
	localparam logic [7:0] TV_HALT = 8'h25;

	localparam logic [2:0] FLAG_P = 3'b001;
	localparam logic [2:0] FLAG_Z = 3'b010;
	localparam logic [2:0] FLAG_N = 3'b100;

	localparam logic [15:0] RESET_PC = 16'h3000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_DECODE,
		S_MEM1,
		S_MEM2,
		S_EXEC,
		S_OUT
	} state_t;

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v == 16'h0000) return FLAG_Z;
		return v[15] ? FLAG_N : FLAG_P;
	endfunction

endpackage

FILE: hw/rtl/lc3_mem.sv
// Single-port synchronous word memory for the LC-3 core.
module lc3_mem #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [15:0]   wdata,
	output logic [15:0]   rdata
);

	logic [15:0] mem [0:(1<<AW)-1];

	// One access per cycle, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: hw/rtl/lc3_instruction_executor.sv
// LC-3 instruction executor top level: sequencer, register file and shared adder.
//
// One transaction is taken at a time. The result can be taken in the cycle after
// acceptance for a load, restart or refused command. An instruction passes through
// S_FETCH, S_DECODE, S_EXEC and S_OUT; LD and LDR add S_MEM1, LDI and STI
// add S_MEM1 and S_MEM2. The single synchronous memory port sets this sequence:
// it does the fetch, then up to two dependent reads. in_stall stays high until
// the cycle after the result is taken, so transactions never overlap.
// Memory holds MEMORY_WORDS words; addresses wrap modulo that size.
// Reading a never-written word returns an undefined value.
module lc3_instruction_executor
	import lc3_pkg::*;
#(
	parameter int MEMORY_WORDS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [0:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [15:0] data,
	input  logic [7:0]  key_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pc_value,
	output logic [15:0] instruction_word,
	output logic        reg_write,
	output logic [2:0]  reg_index,
	output logic [15:0] reg_value,
	output logic [2:0]  cond_flags,
	output logic        mem_write,
	output logic [15:0] mem_address,
	output logic [15:0] mem_value,
	output logic        char_valid,
	output logic [7:0]  char_value,
	output logic [2:0]  status
);

	localparam int AW = $clog2(MEMORY_WORDS);

	state_t state_q, state_d;

	logic [15:0] start_pc_q;
	logic [15:0] pc_q;
	logic [2:0]  flags_q;
	logic        stopped_q;
	logic [15:0] rf_q [0:7];

	logic [7:0]  key_q;
	logic [15:0] ir_q, ea_q;

	// Memory port
	logic          m_we;
	logic [AW-1:0] m_addr;
	logic [15:0]   m_wdata, m_rdata;

	lc3_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
	);

	// Config port
	assign pready = 1'b1;
	assign prdata = {16'h0, start_pc_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pc_q <= RESET_PC;
		end else if (psel && penable && pwrite && paddr == 1'b0) begin
			start_pc_q <= pwdata[15:0];
		end
	end

	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// Instruction fields; in decode the fetched word comes straight from memory
	logic [15:0] ir_w;
	logic [3:0]  op;
	logic [2:0]  dr, sr1, sr2;
	logic [15:0] sx5, sx6, sx9, sx11;
	assign ir_w = (state_q == S_DECODE) ? m_rdata : ir_q;
	assign op   = ir_w[15:12];
	assign dr   = ir_w[11:9];
	assign sr1  = ir_w[8:6];
	assign sr2  = ir_w[2:0];
	assign sx5  = {{11{ir_w[4]}}, ir_w[4:0]};
	assign sx6  = {{10{ir_w[5]}}, ir_w[5:0]};
	assign sx9  = {{7{ir_w[8]}}, ir_w[8:0]};
	assign sx11 = {{5{ir_w[10]}}, ir_w[10:0]};

	// Shared adder: base plus offset, or the two ADD operands
	logic [15:0] add_a, add_b, add_y;
	always_comb begin
		add_a = pc_q;
		add_b = sx9;
		if (state_q == S_DECODE) begin
			unique case (op)
				OP_LDR, OP_STR: begin add_a = rf_q[sr1]; add_b = sx6; end
				OP_JSR:         begin add_a = pc_q;      add_b = sx11; end
				OP_ADD:         begin
					add_a = rf_q[sr1];
					add_b = ir_w[5] ? sx5 : rf_q[sr2];
				end
				default:        begin add_a = pc_q;      add_b = sx9; end
			endcase
		end
	end
	assign add_y = add_a + add_b;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc)
					state_d = (command == CMD_EXEC && !stopped_q) ? S_FETCH : S_OUT;
			end
			S_FETCH:  state_d = S_DECODE;
			S_DECODE: begin
				if (op == OP_LD || op == OP_LDR || op == OP_LDI || op == OP_STI)
					state_d = S_MEM1;
				else
					state_d = S_EXEC;
			end
			S_MEM1:   state_d = (op == OP_LDI || op == OP_STI) ? S_MEM2 : S_EXEC;
			S_MEM2:   state_d = S_EXEC;
			S_EXEC:   state_d = S_OUT;
			S_OUT:    if (out_acc) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		m_we    = 1'b0;
		m_addr  = pc_q[AW-1:0];
		m_wdata = rf_q[dr];
		unique case (state_q)
			S_IDLE: begin
				m_we    = in_acc && command == CMD_LOAD;
				m_addr  = address[AW-1:0];
				m_wdata = data;
			end
			S_MEM1: m_addr = ea_q[AW-1:0];
			S_MEM2: m_addr = m_rdata[AW-1:0];
			S_EXEC: begin
				m_addr = ea_q[AW-1:0];
				m_we   = (op == OP_ST || op == OP_STR || op == OP_STI);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= key_char;
		end
	end

	// Datapath and result registers
	logic [15:0] ldv;
	assign ldv = m_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= RESET_PC;
			flags_q <= FLAG_Z;
			stopped_q <= 1'b0;
			rf_q <= '{default: '0};
			ir_q <= '0; ea_q <= '0;
			instruction_word <= '0; reg_write <= 1'b0; reg_index <= '0;
			reg_value <= '0; mem_write <= 1'b0; mem_address <= '0; mem_value <= '0;
			char_valid <= 1'b0; char_value <= '0; status <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					instruction_word <= '0; reg_write <= 1'b0; reg_index <= '0;
					reg_value <= '0; mem_write <= 1'b0; mem_address <= '0;
					mem_value <= '0; char_valid <= 1'b0; char_value <= '0;
					status <= ST_OK;
					if (command == CMD_LOAD) status <= ST_DONE;
					else if (command == CMD_RESTART) begin
						status <= ST_DONE; pc_q <= start_pc_q;
						flags_q <= FLAG_Z; stopped_q <= 1'b0;
					end else if (command != CMD_EXEC || stopped_q) status <= ST_REFUSED;
				end
				S_FETCH: pc_q <= pc_q + 16'd1;
				S_DECODE: begin
					ir_q <= m_rdata;
					instruction_word <= m_rdata;
				end
				default: ;
			endcase
			// effective address is formed from the word being decoded
			if (state_q == S_DECODE) ea_q <= add_y;
			if (state_q == S_MEM1 && op == OP_LDI) ea_q <= ldv;
			if (state_q == S_MEM2) ea_q <= ldv;
			if (state_q == S_EXEC) begin
				unique case (op)
					OP_BR: if ((dr & flags_q) != 3'b000) pc_q <= ea_q;
					OP_ADD, OP_AND, OP_NOT, OP_LD, OP_LDR, OP_LDI, OP_LEA: begin
						logic [15:0] v;
						v = ea_q;
						if (op == OP_AND) v = rf_q[sr1] & (ir_q[5] ? sx5 : rf_q[sr2]);
						if (op == OP_NOT) v = ~rf_q[sr1];
						if (op == OP_LD || op == OP_LDR || op == OP_LDI) v = ldv;
						rf_q[dr] <= v; flags_q <= flags_of(v);
						reg_write <= 1'b1; reg_index <= dr; reg_value <= v;
					end
					OP_ST, OP_STR, OP_STI: begin
						mem_write <= 1'b1; mem_address <= ea_q; mem_value <= rf_q[dr];
					end
					OP_JMP: pc_q <= rf_q[sr1];
					OP_JSR: begin
						pc_q <= ir_q[11] ? ea_q : rf_q[sr1];
						rf_q[7] <= pc_q;
						reg_write <= 1'b1; reg_index <= 3'd7; reg_value <= pc_q;
					end
					OP_TRAP: begin
						rf_q[7] <= pc_q;
						reg_write <= 1'b1; reg_index <= 3'd7; reg_value <= pc_q;
						if (ir_q[7:0] == TV_GETC || ir_q[7:0] == TV_IN) begin
							rf_q[0] <= {8'h00, key_q};
							reg_index <= 3'd0; reg_value <= {8'h00, key_q};
							flags_q <= flags_of({8'h00, key_q});
							if (ir_q[7:0] == TV_IN) begin
								char_valid <= 1'b1; char_value <= key_q;
							end
						end else if (ir_q[7:0] == TV_OUT) begin
							char_valid <= 1'b1; char_value <= rf_q[0][7:0];
						end else if (ir_q[7:0] == TV_HALT) begin
							stopped_q <= 1'b1; status <= ST_HALT;
						end
					end
					default: begin
						stopped_q <= 1'b1; status <= ST_ILLEGAL;
					end
				endcase
			end
		end
	end

	assign pc_value   = pc_q;
	assign cond_flags = flags_q;

endmodule

FILE: hw/rtl/lc3_checker.sv
// Port-level assertions for the LC-3 executor, bound to the top level.
module lc3_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [2:0]  cond_flags,
	input logic        reg_write,
	input logic        mem_write
);

	// A result never shows up without the input side being blocked
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result while input open");

	// Flags are one-hot whenever a result is offered
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(cond_flags)) else $error("flags not one-hot");

	// A stalled result holds its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("result dropped");

	// Register and memory writes never report together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reg_write && mem_write)) else $error("double write");

endmodule

bind lc3_instruction_executor lc3_assertions u_lc3_assertions (.*);
